### design/rwg_pkg.sv
// ----------------------------------------------------------------------------
// rwg_pkg
// Constants, register codes and the exp(-x) table for the Ricker wavelet
// generator.
// ----------------------------------------------------------------------------
package rwg_pkg;

    localparam int MAX_SAMPLES     = 65536;
    localparam int EXP_TABLE_DEPTH = 256;

    // trace length counter wide enough for the register and the limit
    localparam int MS_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W = (MS_W > 17) ? MS_W : 17;

    // table index, one extra entry at the end for interpolation
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int POS_W     = 34 + EXP_IDX_W;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [36:0] ONE_Q30 = 37'h0_4000_0000;

    // 1.5 s expressed as 3 * 2^47, divided by fc in Q16.16
    localparam int          DIV_STEPS   = 49;
    localparam int          DIV_CNT_W   = 6;
    localparam logic [48:0] DELAY_NUM   = 49'h1_8000_0000_0000;
    localparam logic [48:0] DELAY_RESET = 49'd644245094;

    localparam int NUM_STAGES = 11;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP        = 3'd0,
        REG_CENTER_FREQUENCY = 3'd1,
        REG_AMPLITUDE        = 3'd2,
        REG_TIME_SHIFT       = 3'd3,
        REG_NUM_SAMPLES      = 3'd4
    } cfg_reg_t;

    typedef logic [32:0] exp_word_t;
    typedef exp_word_t [EXP_TABLE_DEPTH:0] exp_tab_t;

    // exp(-16k/D) in Q32, ratio from a truncated taylor series, entries chained
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t            tab;
        logic [63:0]         h;
        logic [63:0]         term;
        logic [63:0]         r;
        logic [63:0]         prod;
        logic signed [65:0]  sum;
        h    = (64'd16 << 32) / EXP_TABLE_DEPTH;
        term = 64'h1_0000_0000;
        sum  = 66'sh1_0000_0000;
        for (int k = 1; k <= 24; k++)
        begin
            term = ((term * h) >> 32) / 64'(k);
            if ((k & 1) != 0)
                sum = sum - $signed({2'b00, term});
            else
                sum = sum + $signed({2'b00, term});
        end
        r      = sum[63:0];
        tab[0] = 33'h1_0000_0000;
        for (int k = 1; k <= EXP_TABLE_DEPTH; k++)
        begin
            prod   = {31'd0, tab[k-1]} * r + 64'h8000_0000;
            tab[k] = {1'b0, prod[63:32]};
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

### design/ricker_wavelet_generator_top.sv
// ----------------------------------------------------------------------------
// ricker_wavelet_generator_top
// Fixed point Ricker wavelet sample generator, one sample per index.
// Pipelined from accepted index to result; throughput one per cycle when not stalled or dividing.
// The pipeline stalls as a whole only while the result register is held.
// A write of center_frequency starts a serial divide for the 1.5/fc delay;
// no index is taken until it ends.
// Reset (rst_n low, asynchronous) restores register defaults and empties the
// pipeline.
// ----------------------------------------------------------------------------
module ricker_wavelet_generator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [rwg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [15:0]                   sample_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            sample_value,
    output logic                          last,
    output logic                          out_of_range
);
    import rwg_pkg::*;

    localparam int NL = NUM_STAGES - 1;

    // configuration
    logic [31:0]        time_step_reg;
    logic [31:0]        center_frequency_reg;
    logic [31:0]        amplitude_reg;
    logic [31:0]        time_shift_reg;
    logic [16:0]        num_samples_reg;

    // delay divider
    logic                 div_busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [31:0]          div_rem_reg;
    logic [31:0]          div_den_reg;
    logic [48:0]          div_q_reg;
    logic [48:0]          delay_reg;
    logic [32:0]          div_trial;
    logic                 div_ge;
    logic [32:0]          div_diff;
    logic [31:0]          div_rem_next;
    logic [48:0]          div_q_next;

    // pipeline control
    logic                  adv;
    logic [NL:0]           vld_reg;
    logic [NL:0]           lst_reg;
    logic [NL:0]           oor_reg;
    logic [NL:0]           zr_reg;
    logic [NL:0]           zr_add;

    // stage payload
    logic [47:0]           s1_t_reg;
    logic [50:0]           s2_ad_reg;
    logic [16:0]           s3_hi_reg;
    logic [47:0]           s3_lo_reg;
    logic [32:0]           s4_x_reg;
    logic [31:0]           s5_tau_reg;
    logic [33:0]           s6_s_reg;
    logic [32:0]           s7_e0_reg;
    logic [31:0]           s7_diff_reg;
    logic [29:0]           s7_frac_reg;
    logic [33:0]           s7_s_reg;
    logic [32:0]           s8_e_reg;
    logic signed [36:0]    s8_w_reg;
    logic [36:0]           s9_gmag_reg;
    logic                  s9_gneg_reg;
    logic [68:0]           s10_prod_reg;
    logic                  s10_neg_reg;
    logic signed [31:0]    val_reg;

    // stage logic
    logic [CNT_W-1:0]      cnt_eff;
    logic                  s1_oor;
    logic                  s1_lst;
    logic [47:0]           s1_t;
    logic signed [51:0]    s2_d;
    logic [50:0]           s2_ad;
    logic [31:0]           fc_eff;
    logic [50:0]           s3_hi;
    logic [63:0]           s3_lo;
    logic [48:0]           s4_x;
    logic [62:0]           s5_prod;
    logic [63:0]           s6_sq;
    logic [POS_W-1:0]      s7_pos;
    logic [EXP_IDX_W-1:0]  s7_idx;
    logic [EXP_IDX_W-1:0]  s7_sel;
    logic                  s7_far;
    logic [32:0]           s7_e0;
    logic [32:0]           s7_e1;
    logic [32:0]           s7_diff;
    logic [61:0]           s8_prod;
    logic [32:0]           s8_e;
    logic signed [36:0]    s8_w;
    logic                  s9_wneg;
    logic [36:0]           s9_wneg_val;
    logic [35:0]           s9_wmag;
    logic [60:0]           s9_prod;
    logic [36:0]           s9_m;
    logic                  s10_aneg;
    logic [31:0]           s10_amag;
    logic [68:0]           s10_prod;
    logic [68:0]           s11_rnd;
    logic [38:0]           s11_m;
    logic signed [31:0]    s11_v;

    // configuration writes and the 1.5/fc divider
    always_comb
    begin
        div_trial    = {div_rem_reg, DELAY_NUM[div_cnt_reg]};
        div_ge       = div_trial >= {1'b0, div_den_reg};
        div_diff     = div_trial - {1'b0, div_den_reg};
        div_rem_next = div_ge ? div_diff[31:0] : div_trial[31:0];
        div_q_next   = {div_q_reg[47:0], div_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg        <= 32'd4294967;
            center_frequency_reg <= 32'd655360;
            amplitude_reg        <= 32'd65536;
            time_shift_reg       <= 32'd0;
            num_samples_reg      <= 17'd65536;
            div_busy_reg         <= 1'b0;
            div_cnt_reg          <= '0;
            div_rem_reg          <= '0;
            div_den_reg          <= 32'd1;
            div_q_reg            <= '0;
            delay_reg            <= DELAY_RESET;
        end
        else
        begin
            if (div_busy_reg)
            begin
                div_rem_reg <= div_rem_next;
                div_q_reg   <= div_q_next;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    div_busy_reg <= 1'b0;
                    delay_reg    <= div_q_next;
                end
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TIME_STEP:
                    begin
                        time_step_reg <= cfg_data;
                    end
                    REG_CENTER_FREQUENCY:
                    begin
                        center_frequency_reg <= cfg_data;
                        div_den_reg  <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
                        div_busy_reg <= 1'b1;
                        div_cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
                        div_rem_reg  <= '0;
                        div_q_reg    <= '0;
                    end
                    REG_AMPLITUDE:
                    begin
                        amplitude_reg <= cfg_data;
                    end
                    REG_TIME_SHIFT:
                    begin
                        time_shift_reg <= cfg_data;
                    end
                    REG_NUM_SAMPLES:
                    begin
                        num_samples_reg <= cfg_data[16:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // pipeline arithmetic
    always_comb
    begin
        zr_add = '0;

        // stage 1: range flags and t = n * dt
        if (CNT_W'(num_samples_reg) > CNT_W'(MAX_SAMPLES))
            cnt_eff = CNT_W'(MAX_SAMPLES);
        else
            cnt_eff = CNT_W'(num_samples_reg);
        s1_oor = CNT_W'(sample_index) >= cnt_eff;
        s1_lst = !s1_oor && ((CNT_W'(sample_index) + CNT_W'(1)) == cnt_eff);
        s1_t   = 48'(sample_index) * 48'(time_step_reg);

        // stage 2: offset from the peak
        s2_d  = $signed({4'b0, s1_t_reg}) - $signed({3'b0, delay_reg})
              - $signed({{12{time_shift_reg[31]}}, time_shift_reg, 8'b0});
        s2_ad = s2_d[51] ? 51'(-s2_d) : s2_d[50:0];

        // stage 3: scale by fc, high and low halves
        fc_eff    = (center_frequency_reg == 32'd0) ? 32'd1 : center_frequency_reg;
        s3_hi     = 51'(fc_eff) * 51'(s2_ad_reg[50:32]);
        s3_lo     = 64'(fc_eff) * 64'(s2_ad_reg[31:0]);
        zr_add[2] = |s3_hi[50:17];

        // stage 4: cycles since peak
        s4_x      = 49'({s3_hi_reg, 16'b0}) + 49'(s3_lo_reg);
        zr_add[3] = |s4_x[48:33];

        // stage 5: tau
        s5_prod   = 63'(s4_x_reg[32:2]) * 63'(PI_Q30);
        zr_add[4] = s5_prod[62];

        // stage 6: tau squared
        s6_sq = 64'(s5_tau_reg) * 64'(s5_tau_reg);

        // stage 7: table position and lookup
        s7_pos    = POS_W'(s6_s_reg) * POS_W'(EXP_TABLE_DEPTH);
        s7_idx    = s7_pos[POS_W-1:34];
        s7_far    = s7_idx >= EXP_IDX_W'(EXP_TABLE_DEPTH);
        s7_sel    = s7_far ? '0 : s7_idx;
        s7_e0     = EXP_TAB[s7_sel];
        s7_e1     = EXP_TAB[s7_sel + 1'b1];
        s7_diff   = s7_e0 - s7_e1;
        zr_add[6] = s7_far;

        // stage 8: interpolate, polynomial term
        s8_prod = 62'(s7_diff_reg) * 62'(s7_frac_reg);
        s8_e    = s7_e0_reg - 33'(s8_prod[61:30]);
        s8_w    = $signed(ONE_Q30) - $signed({2'b0, s7_s_reg, 1'b0});

        // stage 9: g = w * e, rounded on the magnitude
        s9_wneg     = s8_w_reg[36];
        s9_wneg_val = 37'(-s8_w_reg);
        s9_wmag     = s9_wneg ? s9_wneg_val[35:0] : s8_w_reg[35:0];
        s9_prod     = 61'(s9_wmag) * 61'(s8_e_reg[32:8]) + 61'h80_0000;
        s9_m        = s9_prod[60:24];

        // stage 10: amplitude product
        s10_aneg = amplitude_reg[31];
        s10_amag = s10_aneg ? (32'd0 - amplitude_reg) : amplitude_reg;
        s10_prod = 69'(s10_amag) * 69'(s9_gmag_reg);

        // stage 11: round, sign and saturate
        s11_rnd = s10_prod_reg + 69'h2000_0000;
        s11_m   = s11_rnd[68:30];
        if (!s10_neg_reg)
            s11_v = (s11_m > 39'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(s11_m[31:0]);
        else
            s11_v = (s11_m > 39'h8000_0000) ? 32'sh8000_0000
                                            : $signed(32'd0 - s11_m[31:0]);
    end

    assign adv      = !vld_reg[NL] || out_ready;
    assign in_ready = adv && !div_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NL-1:0], in_valid && !div_busy_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lst_reg[0] <= s1_lst;
            oor_reg[0] <= s1_oor;
            zr_reg[0]  <= 1'b0;
            for (int k = 1; k <= NL; k++)
            begin
                lst_reg[k] <= lst_reg[k-1];
                oor_reg[k] <= oor_reg[k-1];
                zr_reg[k]  <= zr_reg[k-1] | zr_add[k];
            end
            s1_t_reg     <= s1_t;
            s2_ad_reg    <= s2_ad;
            s3_hi_reg    <= s3_hi[16:0];
            s3_lo_reg    <= s3_lo[63:16];
            s4_x_reg     <= s4_x[32:0];
            s5_tau_reg   <= s5_prod[61:30];
            s6_s_reg     <= s6_sq[63:30];
            s7_e0_reg    <= s7_e0;
            s7_diff_reg  <= s7_diff[31:0];
            s7_frac_reg  <= s7_pos[33:4];
            s7_s_reg     <= s6_s_reg;
            s8_e_reg     <= s8_e;
            s8_w_reg     <= s8_w;
            s9_gmag_reg  <= s9_m;
            s9_gneg_reg  <= s9_wneg && (s9_m != '0);
            s10_prod_reg <= s10_prod;
            s10_neg_reg  <= s10_aneg != s9_gneg_reg;
            val_reg      <= (zr_reg[NL-1] || oor_reg[NL-1]) ? 32'sd0 : s11_v;
        end
    end

    assign out_valid    = vld_reg[NL];
    assign sample_value = val_reg;
    assign last         = lst_reg[NL];
    assign out_of_range = oor_reg[NL];

`ifndef NO_ASSERTIONS
    // an index past the trace never carries a value or the last mark
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> (sample_value == 32'sd0) && !last)
        else $error("out of range transaction with value or last set");

    // a new centre frequency blocks input until the delay is recomputed
    a_div_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == REG_CENTER_FREQUENCY) |=> !in_ready)
        else $error("input accepted during delay divide");

    // an accepted transaction enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted transaction lost at pipeline entry");
`endif

endmodule

### bench/tb_ricker_wavelet_generator_top.sv
// ----------------------------------------------------------------------------
// tb_ricker_wavelet_generator_top
// Drives sample indices through the Ricker wavelet generator under several
// register settings and checks every sample, last flag and range flag against
// a fixed point predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_ricker_wavelet_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rwg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int                   WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               last;
        logic               out_of_range;
    } wavelet_sample_t;

    class wavelet_scoreboard;
        bit [31:0]       step_q32;
        bit [31:0]       freq_q16;
        int              amp_q16;
        int              shift_q24;
        bit [16:0]       trace_len;
        logic [63:0]     exp_q32 [0:EXP_TABLE_DEPTH];
        wavelet_sample_t pending[$];
        int              errors;
        int              checked;

        function new();
            logic [63:0] h;
            logic [63:0] term;
            longint      acc;
            h    = (64'd16 << 32) / EXP_TABLE_DEPTH;
            term = 64'd1 << 32;
            acc  = longint'(64'd1 << 32);
            for (int k = 1; k <= 24; k++)
            begin
                term = ((term * h) >> 32) / 64'(k);
                acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            exp_q32[0] = 64'd1 << 32;
            for (int k = 1; k <= EXP_TABLE_DEPTH; k++)
                exp_q32[k] = (exp_q32[k-1] * 64'(acc) + 64'h8000_0000) >> 32;
            step_q32  = 32'd4294967;
            freq_q16  = 32'd655360;
            amp_q16   = 65536;
            shift_q24 = 0;
            trace_len = 17'd65536;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_TIME_STEP:        step_q32  = data;
                REG_CENTER_FREQUENCY: freq_q16  = data;
                REG_AMPLITUDE:        amp_q16   = data;
                REG_TIME_SHIFT:       shift_q24 = data;
                REG_NUM_SAMPLES:      trace_len = data[16:0];
                default: ;
            endcase
        endfunction

        // signed product, magnitude rounded half up before the shift
        function longint mul_round(longint a, longint b, int sh);
            logic [63:0] ma;
            logic [63:0] mb;
            logic [63:0] m;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            m  = (ma * mb + (64'd1 << (sh - 1))) >> sh;
            return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        endfunction

        function logic [31:0] wavelet_at(logic [15:0] n);
            logic [63:0] fc;
            logic [63:0] t;
            logic [63:0] ad;
            logic [63:0] hi;
            logic [63:0] x;
            logic [63:0] tau;
            logic [63:0] s;
            logic [63:0] p;
            logic [63:0] idx;
            logic [63:0] frac;
            logic [63:0] e;
            longint      d;
            longint      w;
            longint      g;
            longint      v;
            fc = (freq_q16 != 0) ? 64'(freq_q16) : 64'd1;
            t  = 64'(n) * 64'(step_q32);
            d  = longint'(t) - longint'((64'd3 << 47) / fc) - longint'(shift_q24) * 256;
            ad = (d < 0) ? -d : d;
            hi = fc * (ad >> 32);
            if (hi >= (64'd1 << 17))
                return 0;
            x = (hi << 16) + ((fc * {32'd0, ad[31:0]}) >> 16);
            if (x >= (64'd2 << 32))
                return 0;
            tau = ((x >> 2) * 64'(PI_Q30)) >> 30;
            if (tau >= (64'd4 << 30))
                return 0;
            s    = (tau * tau) >> 30;
            p    = (s * EXP_TABLE_DEPTH) >> 4;
            idx  = p >> 30;
            frac = p & ((64'd1 << 30) - 1);
            if (idx >= EXP_TABLE_DEPTH)
                return 0;
            e = exp_q32[idx] - (((exp_q32[idx] - exp_q32[idx+1]) * frac) >> 30);
            w = longint'(64'd1 << 30) - 2 * longint'(s);
            g = mul_round(w, longint'(e >> 8), 24);
            v = mul_round(longint'(amp_q16), g, 30);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function void note_index(logic [15:0] n);
            wavelet_sample_t r;
            int unsigned     len;
            len = (trace_len > MAX_SAMPLES) ? MAX_SAMPLES : trace_len;
            if (n >= len)
                r = '{sample_value: 0, last: 1'b0, out_of_range: 1'b1};
            else
                r = '{sample_value: wavelet_at(n), last: (n + 1 == len),
                      out_of_range: 1'b0};
            pending.push_back(r);
        endfunction

        function void check_sample(wavelet_sample_t got);
            wavelet_sample_t want;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected sample %0d last %0b oor %0b", $time,
                         got.sample_value, got.last, got.out_of_range);
                return;
            end
            want = pending.pop_front();
            if (got.sample_value !== want.sample_value)
            begin
                errors++;
                $display("%0t: sample_value expected %0d actual %0d", $time,
                         want.sample_value, got.sample_value);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            end
            if (got.out_of_range !== want.out_of_range)
            begin
                errors++;
                $display("%0t: out_of_range expected %0b actual %0b", $time,
                         want.out_of_range, got.out_of_range);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [15:0]          sample_index;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [31:0]   sample_value;
    logic                 last;
    logic                 out_of_range;

    wavelet_scoreboard sb;
    bit                no_idle;
    int                sent;
    int                phases;
    int                quiet_cycles;

    ricker_wavelet_generator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_index (sample_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_value (sample_value),
        .last         (last),
        .out_of_range (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_sample('{sample_value: sample_value, last: last,
                              out_of_range: out_of_range});

    // cycles without any transaction; the divide after a frequency write is short
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_ricker_wavelet_generator_top: errors");
            $finish;
        end
    end

    task automatic send_index(logic [15:0] n);
        while (!no_idle && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_index <= n;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_index(n);
        sent++;
        no_idle = (sent >= 800 && sent < 1100);
    endtask

    // registers are only written with the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 8) @(posedge clk);
    endtask

    task automatic set_regs(logic [31:0] step, logic [31:0] freq, logic [31:0] amp,
                            logic [31:0] shift, logic [31:0] len);
        logic [31:0] vals [5];
        vals = '{step, freq, amp, shift, len};
        settle();
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
        end
        if ($urandom_range(3) == 0)
        begin
            cfg_index <= REG_SPARE - CFG_IDX_W'($urandom_range(2));
            cfg_data  <= $urandom;
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        phases++;
    endtask

    task automatic random_phase();
        logic [63:0] freq;
        logic [63:0] lag;
        logic [63:0] step;
        logic [63:0] span;
        longint      peak;
        longint      shift;
        logic [31:0] amp;
        logic [31:0] len;
        int          k;
        k = $urandom_range(9);
        if (k == 0)
            freq = $urandom;
        else if (k < 3)
            freq = $urandom_range(65535);
        else
            freq = ($urandom_range(1, 200) << 16) | $urandom_range(65535);
        if (freq == 0)
            freq = 1;
        lag  = (64'd3 << 47) / freq;
        step = lag / $urandom_range(10, 3000);
        if ($urandom_range(9) == 0)
            step = $urandom;
        if (step == 0)
            step = 1;
        if (step > 64'hffff_ffff)
            step = 64'hffff_ffff;
        k = $urandom_range(9);
        shift = (k < 6) ? 0 : (k < 9) ? ($signed($urandom_range(2000)) - 1000) *
                longint'(lag >> 8) / 4000 : longint'($signed($urandom));
        if (shift > 64'sd2147483647 || shift < -64'sd2147483648)
            shift = 0;
        k   = $urandom_range(9);
        amp = (k < 4) ? $urandom : (k < 7) ? ($urandom_range(1 << 20) - (1 << 19))
                                            : 32'(65536);
        peak = (longint'(lag) + shift * 256) / longint'(step);
        span = 2 * ((64'd1 << 48) / freq) / step + 2;
        k   = $urandom_range(9);
        len = (k < 6) ? 32'd65536 : (k < 8) ? $urandom_range(1, 65536) :
              (k < 9) ? $urandom : 32'(peak + 1);
        set_regs(step[31:0], freq[31:0], amp, shift[31:0], len);
        repeat ($urandom_range(40, 80))
        begin
            k = $urandom_range(19);
            if (k < 14 && peak >= -longint'(span) && peak <= 65535 + longint'(span))
            begin
                longint n;
                n = peak - longint'(span) + $urandom_range(2 * int'(span > 30000 ?
                    30000 : span));
                send_index((n < 0) ? 16'd0 : (n > 65535) ? 16'hffff : n[15:0]);
            end
            else if (k < 16)
                send_index(16'(len[16:0] - $urandom_range(1)));
            else
                send_index(16'($urandom));
        end
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_TIME_STEP;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample_index = '0;
        out_ready    = 1'b0;
        no_idle      = 1'b0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: peak near index 150, full trace length
        send_index(0);
        send_index(150);
        send_index(149);
        send_index(151);
        send_index(120);
        send_index(65534);
        send_index(65535);
        // smallest step and frequency, zero length: all out of range
        set_regs(32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
        send_index(0);
        send_index(65535);
        set_regs(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h0001_ffff);
        send_index(0);
        send_index(1);
        send_index(65535);
        set_regs(32'd4294967, 32'd655360, 32'h8000_0000, 32'd0, 32'd1);
        send_index(0);
        send_index(1);
        send_index(150);
        set_regs(32'd4294967, 32'd655360, 32'h7fff_ffff, 32'd0, 32'd200);
        send_index(150);
        send_index(199);
        send_index(200);
        send_index(165);

        while (sent < 1800)
            random_phase();
        settle();

        $display("%0d register settings, %0d indices sent, %0d samples checked",
                 phases, sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_ricker_wavelet_generator_top: clean");
        else
            $display("tb_ricker_wavelet_generator_top: errors");
        $finish;
    end

endmodule

### sim.f
design/rwg_pkg.sv
design/ricker_wavelet_generator_top.sv
bench/tb_ricker_wavelet_generator_top.sv
